FILE: hdl/tpr_pkg.sv
package tpr_pkg;

   localparam int unsigned MAP_ENTRIES_DEF = 4096;
   localparam int unsigned TILE_COUNT_DEF  = 2048;
   localparam int unsigned QUEUE_DEPTH     = 4;
   localparam int unsigned INDEX_W         = 14;
   localparam int unsigned CSR_INDEX_W     = 3;
   localparam int unsigned LOG2_MAX        = 6;

   typedef enum logic [1:0] {
      FUNC_RENDER = 2'd0,
      FUNC_MAP    = 2'd1,
      FUNC_ROW    = 2'd2,
      FUNC_PAL    = 2'd3
   } func_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT_X  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT_Y  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_W    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_H    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKDROP = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEYED    = 3'd6;

   typedef struct packed {
      logic        enabled;
      logic [15:0] shift_x;
      logic [15:0] shift_y;
      logic [2:0]  w_log2;
      logic [2:0]  h_log2;
      logic [31:0] backdrop;
      logic        keyed;
   } cfg_type;

   // addr holds the store address already folded into range; fx/fy the
   // pixel position inside the tile for render items
   typedef struct packed {
      func_type           func;
      logic [INDEX_W-1:0] addr;
      logic [2:0]         fx;
      logic [2:0]         fy;
      logic [31:0]        data;
   } item_type;

   // v mod m for v below 256*m, by conditional subtraction of m<<k
   function automatic logic [INDEX_W-1:0] fold_mod(input logic [INDEX_W-1:0] v,
                                                   input int unsigned m);
      logic [21:0] r;
      logic [21:0] d;
      r = {8'd0, v};
      for (int k = 7; k >= 0; k--) begin
         d = 22'(m) << k;
         if (r >= d) r = r - d;
      end
      return r[INDEX_W-1:0];
   endfunction

endpackage

FILE: hdl/tpr_front.sv
module tpr_front #(
   parameter int unsigned MAP_ENTRIES = tpr_pkg::MAP_ENTRIES_DEF,
   parameter int unsigned TILE_COUNT  = tpr_pkg::TILE_COUNT_DEF
) (
   input  tpr_pkg::cfg_type  cfg,
   input  logic              start,
   input  logic              busy,
   input  logic [1:0]        req_func,
   input  logic [11:0]       req_pixel_x,
   input  logic [11:0]       req_pixel_y,
   input  logic signed [15:0] req_line_offset,
   input  logic [13:0]       req_write_index,
   input  logic [31:0]       req_write_data,
   output logic              push,
   output tpr_pkg::item_type item
);
   import tpr_pkg::*;

   localparam int unsigned ROW_SLOTS = TILE_COUNT * 8;

   logic [15:0]        wx;
   logic [15:0]        wy;
   logic [2:0]         wl;
   logic [2:0]         hl;
   logic [5:0]         col;
   logic [5:0]         row;
   logic [INDEX_W-1:0] map_raw;
   func_type           func;

   always_comb begin
      func = func_type'(req_func);
      wx   = {4'd0, req_pixel_x} + cfg.shift_x + $unsigned(req_line_offset);
      wy   = {4'd0, req_pixel_y} + cfg.shift_y;
      wl   = (cfg.w_log2 > 3'(LOG2_MAX)) ? 3'(LOG2_MAX) : cfg.w_log2;
      hl   = (cfg.h_log2 > 3'(LOG2_MAX)) ? 3'(LOG2_MAX) : cfg.h_log2;
      col  = wx[8:3] & 6'((7'd1 << wl) - 7'd1);
      row  = wy[8:3] & 6'((7'd1 << hl) - 7'd1);
      map_raw = (INDEX_W'(row) << wl) | INDEX_W'(col);

      push      = start && !busy;
      item.func = func;
      item.fx   = wx[2:0];
      item.fy   = wy[2:0];
      item.data = req_write_data;
      unique case (func)
         FUNC_RENDER: item.addr = fold_mod(map_raw, MAP_ENTRIES);
         FUNC_MAP:    item.addr = fold_mod(req_write_index, MAP_ENTRIES);
         FUNC_ROW:    item.addr = fold_mod(req_write_index, ROW_SLOTS);
         FUNC_PAL:    item.addr = {8'd0, req_write_index[5:0]};
         default:     item.addr = '0;
      endcase
   end

endmodule

FILE: hdl/tpr_queue.sv
module tpr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tpr_pkg::item_type push_item,
   input  logic              pop,
   output logic              head_valid,
   output tpr_pkg::item_type head_item,
   output logic              full
);
   import tpr_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

   item_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               do_pop;

   always_comb begin
      head_valid = count_ff != '0;
      full       = count_ff == (PTR_W+1)'(QUEUE_DEPTH);
      head_item  = slot_ff[rd_ptr_ff];
      do_pop     = pop && head_valid;
      wr_ptr_in  = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

endmodule

FILE: hdl/tpr_back.sv
module tpr_back #(
   parameter int unsigned MAP_ENTRIES = tpr_pkg::MAP_ENTRIES_DEF,
   parameter int unsigned TILE_COUNT  = tpr_pkg::TILE_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  tpr_pkg::cfg_type  cfg,
   input  logic              head_valid,
   input  tpr_pkg::item_type head_item,
   output logic              pop,
   output logic              rsp_valid,
   output logic [31:0]       rsp_color,
   output logic              rsp_transparent
);
   import tpr_pkg::*;

   localparam int unsigned ROW_SLOTS = TILE_COUNT * 8;
   localparam int unsigned MAP_AW    = $clog2(MAP_ENTRIES);
   localparam int unsigned ROW_AW    = $clog2(ROW_SLOTS);

   typedef struct packed {
      item_type   it;
      logic [1:0] pal;
      logic       clear;
   } stage_type;

   logic [15:0] name_mem [MAP_ENTRIES];
   logic [31:0] row_mem  [ROW_SLOTS];
   logic [31:0] pal_mem  [64];

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   item_type    s1_ff;
   stage_type   s2_ff, s2_in, s3_ff, s4_ff, s4_in;
   logic [15:0] name_rd_ff;
   logic [31:0] row_rd_ff;
   logic [31:0] pal_rd_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_color_ff;
   logic        rsp_transparent_ff;

   logic [2:0]  fx_eff, fy_eff;
   logic [3:0]  nib;
   logic [5:0]  pal_addr;
   logic        s4_clear;
   logic [31:0] color_in;

   assign pop = head_valid;

   // map entry decode and tile row address
   always_comb begin
      fy_eff = name_rd_ff[12] ? 3'd7 - s1_ff.fy : s1_ff.fy;
      fx_eff = name_rd_ff[11] ? 3'd7 - s1_ff.fx : s1_ff.fx;
      s2_in.it    = s1_ff;
      s2_in.pal   = name_rd_ff[14:13];
      s2_in.clear = name_rd_ff[10:0] == 11'd0;
      if (s1_ff.func == FUNC_RENDER) begin
         s2_in.it.addr = fold_mod({name_rd_ff[10:0], fy_eff}, ROW_SLOTS);
         s2_in.it.fx   = fx_eff;
      end
   end

   always_comb begin
      nib      = row_rd_ff[{3'd7 - s3_ff.it.fx, 2'b00} +: 4];
      pal_addr = (s3_ff.it.func == FUNC_PAL) ? s3_ff.it.addr[5:0] : {s3_ff.pal, nib};
      s4_in       = s3_ff;
      s4_in.clear = s3_ff.clear || nib == 4'd0;
      s4_clear = s4_ff.clear || !cfg.enabled;
      color_in = s4_clear ? (cfg.keyed ? 32'd0 : cfg.backdrop) : pal_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= head_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff && s4_ff.it.func == FUNC_RENDER;
      end
   end

   // each store is written and read at the same stage, so accesses stay in item order
   always_ff @(posedge clock) begin
      s1_ff <= head_item;
      if (head_valid && head_item.func == FUNC_MAP)
         name_mem[head_item.addr[MAP_AW-1:0]] <= head_item.data[15:0];
      name_rd_ff <= name_mem[head_item.addr[MAP_AW-1:0]];

      s2_ff <= s2_in;

      s3_ff <= s2_ff;
      if (v2_ff && s2_ff.it.func == FUNC_ROW)
         row_mem[s2_ff.it.addr[ROW_AW-1:0]] <= s2_ff.it.data;
      row_rd_ff <= row_mem[s2_ff.it.addr[ROW_AW-1:0]];

      s4_ff <= s4_in;
      if (v3_ff && s3_ff.it.func == FUNC_PAL)
         pal_mem[pal_addr] <= s3_ff.it.data;
      pal_rd_ff <= pal_mem[pal_addr];

      rsp_color_ff       <= color_in;
      rsp_transparent_ff <= s4_clear;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color       = rsp_color_ff;
   assign rsp_transparent = rsp_transparent_ff;

   a_render_gives_result: assert property (@(posedge clock) disable iff (reset)
      (head_valid && head_item.func == FUNC_RENDER) |=> ##4 rsp_valid_ff)
      else $error("render item produced no result");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      (!head_valid || head_item.func != FUNC_RENDER) |=> ##4 !rsp_valid_ff)
      else $error("result without a render item");

   a_drawn_color_from_palette: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && s4_ff.it.func == FUNC_RENDER && !s4_clear)
      |=> (!rsp_transparent_ff && rsp_color_ff == $past(pal_rd_ff)))
      else $error("drawn pixel color does not match palette read");

endmodule

FILE: hdl/tile_plane_pixel_renderer_core.sv
// Tile-map plane renderer, one 4bpp pixel per item.
// Request channel: an item is taken at a rising edge with start high and
// busy low. req_func selects render pixel, write map entry, write tile row
// or write palette slot; write items fill the on-chip stores and give no
// result, render items give exactly one.
// Result channel: rsp_valid marks rsp_color/rsp_transparent for one cycle;
// the receiver cannot stall, so results never back up.
// A render result passes the queue, map read, row address, tile row read,
// palette read and output registers in that order before it is strobed.
// Throughput: one item per clock, set by the back pipeline, which takes one
// item from the queue every cycle through its single-port stores. busy
// only rises if the 4-entry queue fills, which this pipeline never lets
// happen in steady operation.
// Configuration: csr_we/csr_index/csr_data write the plane registers;
// change them only while no item is in flight.
// Reset clears the registers (map size back to 32x32 tiles), the queue and
// the pipeline valids. The stores are not cleared: an entry must be written
// before it is read.
module tile_plane_pixel_renderer_core #(
   parameter int unsigned MAP_ENTRIES = tpr_pkg::MAP_ENTRIES_DEF,
   parameter int unsigned TILE_COUNT  = tpr_pkg::TILE_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_func,
   input  logic [11:0]                       req_pixel_x,
   input  logic [11:0]                       req_pixel_y,
   input  logic signed [15:0]                req_line_offset,
   input  logic [13:0]                       req_write_index,
   input  logic [31:0]                       req_write_data,
   output logic                              rsp_valid,
   output logic [31:0]                       rsp_color,
   output logic                              rsp_transparent,
   input  logic                              csr_we,
   input  logic [tpr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [31:0]                       csr_data
);
   import tpr_pkg::*;

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   logic     push;
   item_type push_item;
   logic     head_valid;
   item_type head_item;
   logic     pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE:   cfg_in.enabled  = csr_data[0];
            CSR_SHIFT_X:  cfg_in.shift_x  = csr_data[15:0];
            CSR_SHIFT_Y:  cfg_in.shift_y  = csr_data[15:0];
            CSR_MAP_W:    cfg_in.w_log2   = csr_data[2:0];
            CSR_MAP_H:    cfg_in.h_log2   = csr_data[2:0];
            CSR_BACKDROP: cfg_in.backdrop = csr_data;
            CSR_KEYED:    cfg_in.keyed    = csr_data[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled  <= 1'b0;
         cfg_ff.shift_x  <= '0;
         cfg_ff.shift_y  <= '0;
         cfg_ff.w_log2   <= 3'd5;
         cfg_ff.h_log2   <= 3'd5;
         cfg_ff.backdrop <= '0;
         cfg_ff.keyed    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tpr_front #(
      .MAP_ENTRIES(MAP_ENTRIES),
      .TILE_COUNT (TILE_COUNT)
   ) u_front (
      .cfg            (cfg_ff),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .req_line_offset(req_line_offset),
      .req_write_index(req_write_index),
      .req_write_data (req_write_data),
      .push           (push),
      .item           (push_item)
   );

   tpr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_valid(head_valid),
      .head_item (head_item),
      .full      (busy)
   );

   tpr_back #(
      .MAP_ENTRIES(MAP_ENTRIES),
      .TILE_COUNT (TILE_COUNT)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .head_valid     (head_valid),
      .head_item      (head_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_color      (rsp_color),
      .rsp_transparent(rsp_transparent)
   );

endmodule

FILE: verif/tile_plane_pixel_renderer_core_tb.sv
`timescale 1ns / 100ps

module tile_plane_pixel_renderer_core_tb;

   import tpr_pkg::*;

   localparam int unsigned ROW_SLOTS   = TILE_COUNT_DEF * 8;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PHASES      = 8;
   localparam int unsigned PHASE_ITEMS = 60;

   typedef struct packed {
      logic [31:0] color;
      logic        transparent;
   } pixel_result_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   func_type               req_func;
   logic [11:0]            req_pixel_x;
   logic [11:0]            req_pixel_y;
   logic signed [15:0]     req_line_offset;
   logic [13:0]            req_write_index;
   logic [31:0]            req_write_data;
   logic                   rsp_valid;
   logic [31:0]            rsp_color;
   logic                   rsp_transparent;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0]            csr_data;

   // mirror of the plane registers and stores
   logic        cfg_enabled;
   logic [15:0] cfg_shift_x;
   logic [15:0] cfg_shift_y;
   logic [2:0]  cfg_w_log2;
   logic [2:0]  cfg_h_log2;
   logic [31:0] cfg_backdrop;
   logic        cfg_keyed;
   logic [15:0] map_mirror [MAP_ENTRIES_DEF];
   logic [31:0] row_mirror [ROW_SLOTS];
   logic [31:0] pal_mirror [64];
   bit          map_written [MAP_ENTRIES_DEF];
   bit          row_written [ROW_SLOTS];
   bit          pal_written [64];

   pixel_result_type pending_pixels [$];
   int unsigned      mismatches = 0;
   int unsigned      cycle_count = 0;

   tile_plane_pixel_renderer_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_line_offset (req_line_offset),
      .req_write_index (req_write_index),
      .req_write_data  (req_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_color       (rsp_color),
      .rsp_transparent (rsp_transparent),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tile_plane_pixel_renderer_core: mismatch");
         $finish;
      end
   end

   function automatic pixel_result_type shade_pixel(input logic [11:0] px,
                                                    input logic [11:0] py,
                                                    input logic [15:0] lo);
      logic [31:0]      wx;
      logic [31:0]      wy;
      logic [2:0]       wl;
      logic [2:0]       hl;
      logic [31:0]      col;
      logic [31:0]      row;
      logic [15:0]      entry;
      logic [2:0]       fx;
      logic [2:0]       fy;
      logic [31:0]      line;
      logic [3:0]       nib;
      pixel_result_type res;
      nib = 4'd0;
      entry = '0;
      if (cfg_enabled) begin
         wx = {20'd0, px} + {{16{cfg_shift_x[15]}}, cfg_shift_x} + {{16{lo[15]}}, lo};
         wy = {20'd0, py} + {{16{cfg_shift_y[15]}}, cfg_shift_y};
         // log2 of 7 behaves as 6
         wl = (cfg_w_log2 > 3'd6) ? 3'd6 : cfg_w_log2;
         hl = (cfg_h_log2 > 3'd6) ? 3'd6 : cfg_h_log2;
         col = (wx >> 3) & ((32'd1 << wl) - 32'd1);
         row = (wy >> 3) & ((32'd1 << hl) - 32'd1);
         entry = map_mirror[((row << wl) | col) % MAP_ENTRIES_DEF];
         if (entry[10:0] != 11'd0) begin
            fy = entry[12] ? ~wy[2:0] : wy[2:0];
            fx = entry[11] ? ~wx[2:0] : wx[2:0];
            line = row_mirror[{entry[10:0], fy}];
            nib = 4'((line >> (28 - 4 * int'(fx))) & 32'h0F);
         end
      end
      if (nib != 4'd0) begin
         res.color = pal_mirror[{entry[14:13], nib}];
         res.transparent = 1'b0;
      end else begin
         res.color = cfg_keyed ? 32'd0 : cfg_backdrop;
         res.transparent = 1'b1;
      end
      return res;
   endfunction

   always @(posedge clock) begin : check_results
      pixel_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected result, expected none actual color %h transparent %b",
                     $time, rsp_color, rsp_transparent);
            mismatches++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_color !== want.color) begin
               $display("%0t: color expected %h actual %h", $time, want.color, rsp_color);
               mismatches++;
            end
            if (rsp_transparent !== want.transparent) begin
               $display("%0t: transparent expected %b actual %b",
                        $time, want.transparent, rsp_transparent);
               mismatches++;
            end
         end
      end
   end

   task automatic issue_item(input func_type f, input logic [11:0] px, input logic [11:0] py,
                             input logic [15:0] lo, input logic [13:0] widx,
                             input logic [31:0] wdata);
      @(negedge clock);
      start = 1'b1;
      req_func = f;
      req_pixel_x = px;
      req_pixel_y = py;
      req_line_offset = lo;
      req_write_index = widx;
      req_write_data = wdata;
      do @(posedge clock); while (busy);
      case (f)
         FUNC_MAP: begin
            map_mirror[widx % MAP_ENTRIES_DEF] = wdata[15:0];
            map_written[widx % MAP_ENTRIES_DEF] = 1'b1;
         end
         FUNC_ROW: begin
            row_mirror[widx % ROW_SLOTS] = wdata;
            row_written[widx % ROW_SLOTS] = 1'b1;
         end
         FUNC_PAL: begin
            pal_mirror[widx[5:0]] = wdata;
            pal_written[widx[5:0]] = 1'b1;
         end
         FUNC_RENDER: pending_pixels.push_back(shade_pixel(px, py, lo));
      endcase
   endtask

   task automatic store_write(input func_type f, input logic [13:0] widx,
                              input logic [31:0] wdata);
      issue_item(f, 12'($urandom), 12'($urandom), 16'($urandom), widx, wdata);
   endtask

   // write every store entry this render would read that has not been written yet
   task automatic prime_stores(input logic [11:0] px, input logic [11:0] py,
                               input logic [15:0] lo);
      logic [31:0] wx;
      logic [31:0] wy;
      logic [2:0]  wl;
      logic [2:0]  hl;
      logic [31:0] col;
      logic [31:0] row;
      int unsigned map_addr;
      int unsigned row_addr;
      logic [15:0] entry;
      logic [2:0]  fx;
      logic [2:0]  fy;
      logic [3:0]  nib;
      logic [5:0]  slot;
      if (!cfg_enabled) return;
      wx = {20'd0, px} + {{16{cfg_shift_x[15]}}, cfg_shift_x} + {{16{lo[15]}}, lo};
      wy = {20'd0, py} + {{16{cfg_shift_y[15]}}, cfg_shift_y};
      wl = (cfg_w_log2 > 3'd6) ? 3'd6 : cfg_w_log2;
      hl = (cfg_h_log2 > 3'd6) ? 3'd6 : cfg_h_log2;
      col = (wx >> 3) & ((32'd1 << wl) - 32'd1);
      row = (wy >> 3) & ((32'd1 << hl) - 32'd1);
      map_addr = ((row << wl) | col) % MAP_ENTRIES_DEF;
      if (!map_written[map_addr]) store_write(FUNC_MAP, 14'(map_addr), $urandom);
      entry = map_mirror[map_addr];
      if (entry[10:0] == 11'd0) return;
      fy = entry[12] ? ~wy[2:0] : wy[2:0];
      fx = entry[11] ? ~wx[2:0] : wx[2:0];
      row_addr = 32'({entry[10:0], fy}) % ROW_SLOTS;
      if (!row_written[row_addr]) store_write(FUNC_ROW, 14'(row_addr), $urandom);
      nib = row_mirror[row_addr][(28 - 4 * int'(fx)) +: 4];
      if (nib == 4'd0) return;
      slot = {entry[14:13], nib};
      if (!pal_written[slot]) store_write(FUNC_PAL, 14'(slot), $urandom);
   endtask

   // unused fields of an item carry random values
   task automatic render_pixel(input logic [11:0] px, input logic [11:0] py,
                               input logic [15:0] lo);
      prime_stores(px, py, lo);
      issue_item(FUNC_RENDER, px, py, lo, 14'($urandom), $urandom);
   endtask

   task automatic pause(input int unsigned cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 20);
   endfunction

   // write items give no result, so allow the pipeline depth after the last one
   task automatic settle();
      @(negedge clock);
      start = 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_data = data;
      case (idx)
         CSR_ENABLE:   cfg_enabled = data[0];
         CSR_SHIFT_X:  cfg_shift_x = data[15:0];
         CSR_SHIFT_Y:  cfg_shift_y = data[15:0];
         CSR_MAP_W:    cfg_w_log2 = data[2:0];
         CSR_MAP_H:    cfg_h_log2 = data[2:0];
         CSR_BACKDROP: cfg_backdrop = data;
         CSR_KEYED:    cfg_keyed = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic test_disabled_plane();
      render_pixel(12'd0, 12'd0, 16'd0);
      render_pixel(12'hFFF, 12'hFFF, 16'h8000);
      settle();
      set_reg(CSR_BACKDROP, 32'hA5A5_5A5A);
      render_pixel(12'h800, 12'h001, 16'h7FFF);
      settle();
      set_reg(CSR_KEYED, 32'd1);
      render_pixel(12'h123, 12'h456, 16'd0);
      settle();
      set_reg(CSR_KEYED, 32'd0);
   endtask

   task automatic test_tile_decode();
      set_reg(CSR_ENABLE, 32'd1);
      store_write(FUNC_MAP, 14'd0, 32'hFFFF_0000);     // tile index zero
      store_write(FUNC_MAP, 14'd1, 32'h0000_0805);     // tile 5, hflip
      store_write(FUNC_ROW, 14'd40, 32'h0123_4567);    // tile 5 row 0, leftmost nibble zero
      store_write(FUNC_MAP, 14'd32, 32'h0000_F7FF);    // tile 2047, vflip, palette 3, bit 15
      store_write(FUNC_ROW, 14'h3FFF, 32'hFEDC_BA98);  // tile 2047 row 7
      store_write(FUNC_PAL, 14'h3FFF, 32'hFFFF_FFFF);  // wraps to slot 63
      store_write(FUNC_MAP, 14'd33, 32'h0000_5801);    // tile 1, both flips, palette 2
      render_pixel(12'd0, 12'd0, 16'd0);
      render_pixel(12'd8, 12'd0, 16'd0);
      render_pixel(12'd15, 12'd0, 16'd0);
      render_pixel(12'd0, 12'd8, 16'd0);
      render_pixel(12'd9, 12'd9, 16'd0);
      render_pixel(12'd0, 12'd0, 16'd8);
   endtask

   task automatic test_scroll_and_wrap();
      settle();
      set_reg(CSR_SHIFT_X, 32'h0000_8000);
      set_reg(CSR_SHIFT_Y, 32'h0000_7FFF);
      render_pixel(12'd0, 12'd0, 16'h8000);
      render_pixel(12'hFFF, 12'hFFF, 16'h7FFF);
      render_pixel(12'd100, 12'd7, 16'hFFFF);
      settle();
      set_reg(CSR_SHIFT_X, 32'd0);
      set_reg(CSR_SHIFT_Y, 32'd0);
      set_reg(CSR_MAP_W, 32'd7);
      set_reg(CSR_MAP_H, 32'd7);
      store_write(FUNC_MAP, 14'h3FFF, 32'h0000_FFFF);  // wraps to the last map entry
      render_pixel(12'hFFF, 12'hFFF, 16'd0);
      settle();
      set_reg(CSR_MAP_W, 32'd0);
      set_reg(CSR_MAP_H, 32'd0);
      render_pixel(12'd5, 12'd5, 16'd0);
      render_pixel(12'hABC, 12'h345, 16'h1234);
   endtask

   task automatic test_random_traffic();
      int unsigned r;
      func_type    f;
      logic [13:0] idx;
      logic [31:0] data;
      logic [2:0]  wl;
      logic [2:0]  hl;
      logic [15:0] sx;
      logic [15:0] sy;
      logic [31:0] backdrop;
      bit          no_gaps;
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         sx = 16'($urandom);
         sy = 16'($urandom);
         backdrop = $urandom;
         wl = 3'($urandom_range(0, 7));
         hl = 3'($urandom_range(0, 7));
         case (phase)
            0: begin
               wl = 3'd0; hl = 3'd0; sx = 16'h8000; sy = 16'h7FFF;
            end
            1: begin
               wl = 3'd6; hl = 3'd6; sx = 16'h7FFF; sy = 16'h8000; backdrop = '1;
            end
            2: begin
               wl = 3'd7; hl = 3'd7;
            end
            default: ;
         endcase
         set_reg(CSR_ENABLE, (phase == 3) ? 32'd0 : 32'd1);
         set_reg(CSR_KEYED, 32'(phase % 2));
         set_reg(CSR_MAP_W, 32'(wl));
         set_reg(CSR_MAP_H, 32'(hl));
         set_reg(CSR_SHIFT_X, 32'(sx));
         set_reg(CSR_SHIFT_Y, 32'(sy));
         set_reg(CSR_BACKDROP, backdrop);
         no_gaps = (phase % 3 == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 55) f = FUNC_RENDER;
            else if (r < 70) f = FUNC_MAP;
            else if (r < 90) f = FUNC_ROW;
            else f = FUNC_PAL;
            idx = 14'($urandom);
            data = $urandom;
            case (f)
               FUNC_RENDER: render_pixel(12'($urandom), 12'($urandom),
                                         ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom));
               FUNC_MAP: begin
                  if ($urandom_range(0, 7) == 0) data[10:0] = '0;
                  store_write(f, idx, data);
               end
               FUNC_ROW: begin
                  // more zero nibbles than uniform data gives
                  for (int k = 0; k < 8; k++)
                     if ($urandom_range(0, 3) == 0) data[4*k +: 4] = 4'd0;
                  store_write(f, idx, data);
               end
               default: store_write(f, idx, data);
            endcase
            if (!no_gaps) pause(gap_len());
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_func = FUNC_RENDER;
      req_pixel_x = '0;
      req_pixel_y = '0;
      req_line_offset = '0;
      req_write_index = '0;
      req_write_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_ENABLE;
      csr_data = '0;
      cfg_enabled = 1'b0;
      cfg_shift_x = '0;
      cfg_shift_y = '0;
      cfg_w_log2 = 3'd5;
      cfg_h_log2 = 3'd5;
      cfg_backdrop = '0;
      cfg_keyed = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_disabled_plane();
      test_tile_decode();
      test_scroll_and_wrap();
      test_random_traffic();
      settle();
      if (mismatches == 0) begin
         $display("tile_plane_pixel_renderer_core: match");
      end else begin
         $display("tile_plane_pixel_renderer_core: mismatch");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/tpr_pkg.sv
hdl/tpr_front.sv
hdl/tpr_queue.sv
hdl/tpr_back.sv
hdl/tile_plane_pixel_renderer_core.sv
verif/tile_plane_pixel_renderer_core_tb.sv
